FILE: rtl/core/dur_pkg.sv
// ----------------------------------------------------------------------------
// dur_pkg: shared definitions for the duration string parser
// phase and status codes, unit ranks, character codes and the control struct
// ----------------------------------------------------------------------------
package dur_pkg;

  // default width of counts and totals
  localparam int unsigned VALUE_BITS_DFLT = 31;

  // result field widths
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned SECONDS_W = 31;
  localparam int unsigned OUT_DATA_W = ((STATUS_W + SECONDS_W + 7) / 8) * 8;

  // parse phases
  localparam int unsigned PHASE_W = 3;
  localparam logic [PHASE_W-1:0] PH_START     = 3'd0;
  localparam logic [PHASE_W-1:0] PH_NUMBER    = 3'd1;
  localparam logic [PHASE_W-1:0] PH_UNIT_DONE = 3'd2;
  localparam logic [PHASE_W-1:0] PH_AFTER_M   = 3'd3;
  localparam logic [PHASE_W-1:0] PH_AFTER_MI  = 3'd4;
  localparam logic [PHASE_W-1:0] PH_AFTER_S   = 3'd5;
  localparam logic [PHASE_W-1:0] PH_AFTER_SE  = 3'd6;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_SYNTAX   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_ORDER    = 2'd2;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd3;

  // unit ranks, larger unit has higher rank
  localparam int unsigned RANK_W = 3;
  localparam logic [RANK_W-1:0] RANK_SEC  = 3'd1;
  localparam logic [RANK_W-1:0] RANK_MIN  = 3'd2;
  localparam logic [RANK_W-1:0] RANK_HOUR = 3'd3;
  localparam logic [RANK_W-1:0] RANK_DAY  = 3'd4;
  localparam logic [RANK_W-1:0] RANK_NONE = 3'd5;

  // seconds per unit
  localparam int unsigned MULT_W = 17;
  localparam logic [MULT_W-1:0] MULT_DAY  = 17'd86400;
  localparam logic [MULT_W-1:0] MULT_HOUR = 17'd3600;
  localparam logic [MULT_W-1:0] MULT_MIN  = 17'd60;
  localparam logic [MULT_W-1:0] MULT_SEC  = 17'd1;

  // character codes
  localparam logic [7:0] CHAR_0 = 8'h30;
  localparam logic [7:0] CHAR_9 = 8'h39;
  localparam logic [7:0] CHAR_D = 8'h64;
  localparam logic [7:0] CHAR_H = 8'h68;
  localparam logic [7:0] CHAR_M = 8'h6d;
  localparam logic [7:0] CHAR_S = 8'h73;
  localparam logic [7:0] CHAR_I = 8'h69;
  localparam logic [7:0] CHAR_N = 8'h6e;
  localparam logic [7:0] CHAR_E = 8'h65;
  localparam logic [7:0] CHAR_C = 8'h63;

  // control part of the parser state
  typedef struct packed {
    logic [PHASE_W-1:0]  phase;
    logic [RANK_W-1:0]   rank;
    logic [STATUS_W-1:0] err;
  } ctrl_t;

  localparam ctrl_t CTRL_RESET = '{phase: PH_START, rank: RANK_NONE, err: ST_OK};

endpackage

FILE: rtl/core/dur_step.sv
// ----------------------------------------------------------------------------
// dur_step: one character step of the duration parser
// next state and end-of-string result from current state and one character
// ----------------------------------------------------------------------------
module dur_step #(
  parameter int unsigned VALUE_BITS = dur_pkg::VALUE_BITS_DFLT
) (
  input  dur_pkg::ctrl_t                  ctrl_i,
  input  logic [VALUE_BITS-1:0]           count_i,
  input  logic [VALUE_BITS-1:0]           total_i,
  input  logic [7:0]                      char_i,
  input  logic                            last_i,
  output dur_pkg::ctrl_t                  ctrl_o,
  output logic [VALUE_BITS-1:0]           count_o,
  output logic [VALUE_BITS-1:0]           total_o,
  output logic [dur_pkg::STATUS_W-1:0]    status_o,
  output logic [dur_pkg::SECONDS_W-1:0]   seconds_o
);

  localparam int unsigned DW  = VALUE_BITS + 4;
  localparam int unsigned PW  = VALUE_BITS + dur_pkg::MULT_W;
  localparam int unsigned EXW = (VALUE_BITS > dur_pkg::SECONDS_W) ?
                                VALUE_BITS : dur_pkg::SECONDS_W;
  localparam logic [VALUE_BITS-1:0] LIMIT = {VALUE_BITS{1'b1}};

  logic                           is_digit;
  logic [7:0]                     digit_off;
  logic [VALUE_BITS-1:0]          base;
  logic [DW-1:0]                  dig_wide;
  logic                           dig_ovf;
  logic                           is_unit;
  logic [dur_pkg::RANK_W-1:0]     unit_rank;
  logic [dur_pkg::MULT_W-1:0]     unit_mult;
  logic [dur_pkg::PHASE_W-1:0]    unit_phase;
  logic [PW-1:0]                  prod;
  logic                           prod_ovf;
  logic [VALUE_BITS:0]            sum;
  dur_pkg::ctrl_t                 ctrl_n;
  logic [VALUE_BITS-1:0]          count_n;
  logic [VALUE_BITS-1:0]          total_n;
  logic [EXW-1:0]                 total_ext;
  logic                           end_ok;

  // digit accumulate: count * 10 + digit, checked against the value range
  assign is_digit  = (char_i >= dur_pkg::CHAR_0) && (char_i <= dur_pkg::CHAR_9);
  assign digit_off = char_i - dur_pkg::CHAR_0;
  assign base      = (ctrl_i.phase == dur_pkg::PH_NUMBER) ? count_i : '0;
  assign dig_wide  = (DW'(base) << 3) + (DW'(base) << 1) + DW'(digit_off[3:0]);
  assign dig_ovf   = dig_wide > DW'(LIMIT);

  // unit decode
  always_comb begin
    is_unit    = 1'b1;
    unit_rank  = dur_pkg::RANK_SEC;
    unit_mult  = dur_pkg::MULT_SEC;
    unit_phase = dur_pkg::PH_AFTER_S;
    priority if (char_i == dur_pkg::CHAR_D) begin
      unit_rank  = dur_pkg::RANK_DAY;
      unit_mult  = dur_pkg::MULT_DAY;
      unit_phase = dur_pkg::PH_UNIT_DONE;
    end else if (char_i == dur_pkg::CHAR_H) begin
      unit_rank  = dur_pkg::RANK_HOUR;
      unit_mult  = dur_pkg::MULT_HOUR;
      unit_phase = dur_pkg::PH_UNIT_DONE;
    end else if (char_i == dur_pkg::CHAR_M) begin
      unit_rank  = dur_pkg::RANK_MIN;
      unit_mult  = dur_pkg::MULT_MIN;
      unit_phase = dur_pkg::PH_AFTER_M;
    end else if (char_i == dur_pkg::CHAR_S) begin
      unit_rank  = dur_pkg::RANK_SEC;
      unit_mult  = dur_pkg::MULT_SEC;
      unit_phase = dur_pkg::PH_AFTER_S;
    end else begin
      is_unit = 1'b0;
    end
  end

  // component close: one multiply, then add into the running total
  assign prod     = PW'(count_i) * PW'(unit_mult);
  assign prod_ovf = prod > PW'(LIMIT);
  assign sum      = {1'b0, total_i} + {1'b0, prod[VALUE_BITS-1:0]};

  always_comb begin
    ctrl_n  = ctrl_i;
    count_n = count_i;
    total_n = total_i;
    if (ctrl_i.err == dur_pkg::ST_OK) begin
      unique case (ctrl_i.phase)
        dur_pkg::PH_START, dur_pkg::PH_UNIT_DONE, dur_pkg::PH_AFTER_M,
        dur_pkg::PH_AFTER_S: begin
          if ((ctrl_i.phase == dur_pkg::PH_AFTER_M) && (char_i == dur_pkg::CHAR_I)) begin
            ctrl_n.phase = dur_pkg::PH_AFTER_MI;
          end else if ((ctrl_i.phase == dur_pkg::PH_AFTER_S) &&
                       (char_i == dur_pkg::CHAR_E)) begin
            ctrl_n.phase = dur_pkg::PH_AFTER_SE;
          end else if (is_digit) begin
            count_n      = dig_wide[VALUE_BITS-1:0];
            ctrl_n.phase = dur_pkg::PH_NUMBER;
          end else begin
            ctrl_n.err = dur_pkg::ST_SYNTAX;
          end
        end
        dur_pkg::PH_NUMBER: begin
          if (is_digit) begin
            if (dig_ovf) begin
              ctrl_n.err = dur_pkg::ST_OVERFLOW;
            end else begin
              count_n = dig_wide[VALUE_BITS-1:0];
            end
          end else if (is_unit) begin
            // order check comes before the range checks
            if (unit_rank >= ctrl_i.rank) begin
              ctrl_n.err = dur_pkg::ST_ORDER;
            end else if (prod_ovf || sum[VALUE_BITS]) begin
              ctrl_n.err = dur_pkg::ST_OVERFLOW;
            end else begin
              total_n      = sum[VALUE_BITS-1:0];
              count_n      = '0;
              ctrl_n.rank  = unit_rank;
              ctrl_n.phase = unit_phase;
            end
          end else begin
            ctrl_n.err = dur_pkg::ST_SYNTAX;
          end
        end
        dur_pkg::PH_AFTER_MI: begin
          if (char_i == dur_pkg::CHAR_N) begin
            ctrl_n.phase = dur_pkg::PH_UNIT_DONE;
          end else begin
            ctrl_n.err = dur_pkg::ST_SYNTAX;
          end
        end
        dur_pkg::PH_AFTER_SE: begin
          if (char_i == dur_pkg::CHAR_C) begin
            ctrl_n.phase = dur_pkg::PH_UNIT_DONE;
          end else begin
            ctrl_n.err = dur_pkg::ST_SYNTAX;
          end
        end
        default: begin
          ctrl_n.err = dur_pkg::ST_SYNTAX;
        end
      endcase
    end
  end

  // string may only end right after a complete unit
  assign end_ok = (ctrl_n.phase == dur_pkg::PH_UNIT_DONE) ||
                  (ctrl_n.phase == dur_pkg::PH_AFTER_M) ||
                  (ctrl_n.phase == dur_pkg::PH_AFTER_S);

  always_comb begin
    status_o = ctrl_n.err;
    if (last_i && (ctrl_n.err == dur_pkg::ST_OK) && !end_ok) begin
      status_o = dur_pkg::ST_SYNTAX;
    end
  end

  assign total_ext = EXW'(total_n);
  assign seconds_o = (status_o == dur_pkg::ST_OK) ? total_ext[dur_pkg::SECONDS_W-1:0] : '0;
  assign ctrl_o    = ctrl_n;
  assign count_o   = count_n;
  assign total_o   = total_n;

endmodule

FILE: rtl/core/duration_string_parser.sv
// ----------------------------------------------------------------------------
// duration_string_parser: streaming parser for duration text like 1h30m
// takes one character per transaction, gives status and total seconds
// ----------------------------------------------------------------------------
// usage
//   slave side: one character per transaction, tdata = char_code, tlast marks
//   the final character of a string. a string is a run of decimal counts
//   each followed by a unit d, h, m/min or s/sec in strictly descending order.
//   master side: one transaction per string, sent for the tlast character.
//   tdata = status (0 ok, 1 syntax, 2 unit order, 3 overflow) and total
//   seconds (zero unless status is ok).
// throughput
//   one character per cycle sustained while no tlast character waits for the
//   output register. a character is held in the input register and is parsed
//   there; the result of a tlast character is loaded into the output register
//   once that is free, and shows on the master side from there.
//   the loop that sets the pace is the per-character state update, whose
//   longest path is the unit multiply and the add into the running total.
// reset
//   asynchronous active-low reset empties both registers and puts the parser
//   at the start of a string. after every tlast character the parser returns
//   to the same start state by itself.
// stall
//   while a result waits on the master side, characters that give no result
//   keep flowing; a tlast character waits in the input register until the
//   output register is free, and the slave side stalls meanwhile.
// ----------------------------------------------------------------------------
module duration_string_parser #(
  parameter int unsigned VALUE_BITS = dur_pkg::VALUE_BITS_DFLT
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // slave side
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  input  logic [7:0]                       s_axis_tdata_i,  // [7:0] char_code
  input  logic                             s_axis_tlast_i,  // is_last
  // master side
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  output logic [dur_pkg::OUT_DATA_W-1:0]   m_axis_tdata_o   // [1:0] status,
                                                            // [32:2] total_seconds,
                                                            // rest zero
);

  localparam int unsigned PAD_W = dur_pkg::OUT_DATA_W - dur_pkg::STATUS_W
                                  - dur_pkg::SECONDS_W;

  // input register
  logic                          s1_valid_q, s1_valid_d;
  logic [7:0]                    s1_char_q;
  logic                          s1_last_q;

  // parser state
  dur_pkg::ctrl_t                ctrl_q, ctrl_d, ctrl_n;
  logic [VALUE_BITS-1:0]         count_q, count_d, count_n;
  logic [VALUE_BITS-1:0]         total_q, total_d, total_n;

  // result register
  logic                          out_valid_q, out_valid_d;
  logic [dur_pkg::STATUS_W-1:0]  out_status_q, step_status;
  logic [dur_pkg::SECONDS_W-1:0] out_secs_q, step_secs;

  logic                          in_fire;
  logic                          out_free;
  logic                          step_go;
  logic                          out_load;

  // a character without tlast never needs the output register
  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign step_go         = s1_valid_q && (!s1_last_q || out_free);
  assign out_load        = step_go && s1_last_q;
  assign s_axis_tready_o = !s1_valid_q || step_go;
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;

  dur_step #(
    .VALUE_BITS (VALUE_BITS)
  ) u_step (
    .ctrl_i    (ctrl_q),
    .count_i   (count_q),
    .total_i   (total_q),
    .char_i    (s1_char_q),
    .last_i    (s1_last_q),
    .ctrl_o    (ctrl_n),
    .count_o   (count_n),
    .total_o   (total_n),
    .status_o  (step_status),
    .seconds_o (step_secs)
  );

  // state advances on each parsed character, back to start after tlast
  always_comb begin
    ctrl_d  = ctrl_q;
    count_d = count_q;
    total_d = total_q;
    if (step_go) begin
      if (s1_last_q) begin
        ctrl_d  = dur_pkg::CTRL_RESET;
        count_d = '0;
        total_d = '0;
      end else begin
        ctrl_d  = ctrl_n;
        count_d = count_n;
        total_d = total_n;
      end
    end
  end

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_fire) begin
      s1_valid_d = 1'b1;
    end else if (step_go) begin
      s1_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      ctrl_q      <= dur_pkg::CTRL_RESET;
      count_q     <= '0;
      total_q     <= '0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      ctrl_q      <= ctrl_d;
      count_q     <= count_d;
      total_q     <= total_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_char_q <= s_axis_tdata_i;
      s1_last_q <= s_axis_tlast_i;
    end
    if (out_load) begin
      out_status_q <= step_status;
      out_secs_q   <= step_secs;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{PAD_W{1'b0}}, out_secs_q, out_status_q};

  // rejected strings always report zero seconds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && (out_status_q != dur_pkg::ST_OK)) |-> (out_secs_q == '0))
    else $error("nonzero total on rejected string");

  // parser is back at the start after a final character
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> ((ctrl_q == dur_pkg::CTRL_RESET) && (count_q == '0) && (total_q == '0)))
    else $error("parser state not cleared after end of string");

  // first error sticks until the end of the string
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_go && !s1_last_q && (ctrl_q.err != dur_pkg::ST_OK))
      |=> (ctrl_q.err == $past(ctrl_q.err)))
    else $error("error status changed before end of string");

  // only final characters reach the output register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_go && !s1_last_q) |=> (out_valid_q == $past(out_valid_q && !m_axis_tready_i)))
    else $error("result produced by a non-final character");

  // the unit rank only drops within a string
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_go && !s1_last_q) |=> (ctrl_q.rank <= $past(ctrl_q.rank)))
    else $error("unit rank rose within a string");

endmodule
